### design/isingm_pkg.sv
// Shared constants and types for the Ising Metropolis spin update block.
// Holds field widths, the controller state type and the control/status words.
// No dependencies; imported by every file of the block but isingm_ram.
package isingm_pkg;

	// default lattice side
	localparam int SIDE_DEF = 64;

	// field widths
	localparam int SITE_W = 12;
	localparam int RND_W  = 15;
	localparam int MAG_W  = 14;
	localparam int THR_W  = 16;

	// threshold table: entry 5*spin + up_neighbours
	localparam int TBL_N = 10;
	localparam int IDX_W = 4;

	// configuration bus
	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	// configuration register indexes; REG_NONE lies past the table
	typedef enum logic [1:0] {
		REG_TBL_LOW  = 2'd0,
		REG_TBL_MID  = 2'd1,
		REG_TBL_HIGH = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef logic [TBL_N-1:0][THR_W-1:0] thr_table_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_BASE,
		ST_SIDES,
		ST_DECIDE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic step_row;
		logic step_base;
		logic step_sides;
		logic decide;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} status_t;

endpackage

### design/ising_metropolis_spin_update.sv
// Top level of the Ising Metropolis spin update block.
// Depends on isingm_pkg, isingm_regs, isingm_ctrl and isingm_dp.
//
//   channel  handshake           payload
//   req      req_valid/ready     site, accept_random
//   rsp      rsp_valid/ready     accepted, new_spin, magnetization
//   apb      psel/penable/pready pwrite, paddr, pwdata, prdata
//
// An update steps through the row, base, sides and decide states: site split
// by a reciprocal multiply while the own spin is read, then vertical and
// horizontal pairs read from both read ports of the spin memory. A request is
// taken while idle or in the decide state. After reset a clearing pass sets
// every spin up with req_ready low; configuration writes are taken throughout.
// A result waits in the output register; the next word is accepted meanwhile
// and its decide cycle holds until the output register is free.
module ising_metropolis_spin_update #(
	parameter int SIDE = isingm_pkg::SIDE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [isingm_pkg::SITE_W-1:0]       site,
	input  logic [isingm_pkg::RND_W-1:0]        accept_random,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                accepted,
	output logic                                new_spin,
	output logic signed [isingm_pkg::MAG_W-1:0] magnetization,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [isingm_pkg::APB_AW-1:0]       paddr,
	input  logic [isingm_pkg::APB_DW-1:0]       pwdata,
	output logic [isingm_pkg::APB_DW-1:0]       prdata,
	output logic                                pready
);
	import isingm_pkg::*;

	thr_table_t thr_table;
	cmd_t       cmd;
	status_t    sts;

	isingm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.thr_table (thr_table)
	);

	isingm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	isingm_dp #(
		.SIDE (SIDE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.site          (site),
		.accept_random (accept_random),
		.thr_table     (thr_table),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.accepted      (accepted),
		.new_spin      (new_spin),
		.magnetization (magnetization)
	);

endmodule

### design/isingm_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module isingm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### design/isingm_regs.sv
// Configuration registers: the ten acceptance thresholds behind an APB-style port.
// Depends on isingm_pkg.
module isingm_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [isingm_pkg::APB_AW-1:0]  paddr,
	input  logic [isingm_pkg::APB_DW-1:0]  pwdata,
	output logic [isingm_pkg::APB_DW-1:0]  prdata,
	output logic                           pready,
	output isingm_pkg::thr_table_t         thr_table
);
	import isingm_pkg::*;

	localparam logic [63:0] RST_WIDE   = 64'h8000_8000_8000_8000;
	localparam logic [31:0] RST_NARROW = 32'h8000_8000;

	logic [63:0] tbl_low_q;
	logic [63:0] tbl_mid_q;
	logic [31:0] tbl_high_q;
	reg_idx_t    reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_low_q  <= RST_WIDE;
			tbl_mid_q  <= RST_WIDE;
			tbl_high_q <= RST_NARROW;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TBL_LOW:  tbl_low_q  <= pwdata;
				REG_TBL_MID:  tbl_mid_q  <= pwdata;
				REG_TBL_HIGH: tbl_high_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		case (reg_idx)
			REG_TBL_LOW:  prdata = tbl_low_q;
			REG_TBL_MID:  prdata = tbl_mid_q;
			REG_TBL_HIGH: prdata = {32'b0, tbl_high_q};
			default:      prdata = '0;
		endcase
	end

	assign thr_table = {tbl_high_q, tbl_mid_q, tbl_low_q};

endmodule

### design/isingm_ctrl.sv
// Controller: runs the clearing pass and row, base, sides, decide update steps.
// Depends on isingm_pkg.
module isingm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  isingm_pkg::status_t sts,
	output isingm_pkg::cmd_t    cmd
);
	import isingm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_ROW;
			end
			ST_ROW:   state_d = ST_BASE;
			ST_BASE:  state_d = ST_SIDES;
			ST_SIDES: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!sts.out_busy) state_d = req_valid ? ST_ROW : ST_IDLE;
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE:  req_ready = 1'b1;
			ST_ROW:   cmd.step_row = 1'b1;
			ST_BASE:  cmd.step_base = 1'b1;
			ST_SIDES: cmd.step_sides = 1'b1;
			ST_DECIDE: begin
				cmd.decide = !sts.out_busy;
				req_ready  = !sts.out_busy;
			end
			default: ;
		endcase
		cmd.load = req_valid & req_ready;
	end

endmodule

### design/isingm_dp.sv
// Datapath: spin memory, site split, neighbour addressing, threshold test,
// magnetization and result register. Depends on isingm_pkg and isingm_ram.
module isingm_dp #(
	parameter int SIDE = isingm_pkg::SIDE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  isingm_pkg::cmd_t                    cmd,
	output isingm_pkg::status_t                 sts,
	input  logic [isingm_pkg::SITE_W-1:0]       site,
	input  logic [isingm_pkg::RND_W-1:0]        accept_random,
	input  isingm_pkg::thr_table_t              thr_table,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                accepted,
	output logic                                new_spin,
	output logic signed [isingm_pkg::MAG_W-1:0] magnetization
);
	import isingm_pkg::*;

	localparam int SITES  = SIDE * SIDE;
	localparam int DEPTH  = (SITES < 2**SITE_W) ? SITES : 2**SITE_W;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NA_W   = $clog2(SITES);
	// row = (site * DIV_M) >> DIV_S, exact for every 12-bit site
	localparam int DIV_S  = SITE_W + $clog2(SIDE);
	localparam int DIV_M  = (2**DIV_S + SIDE - 1) / SIDE;
	localparam int PROD_W = DIV_S + SITE_W;

	localparam logic [NA_W:0]     DEPTH_V  = (NA_W+1)'(DEPTH);
	localparam logic [16:0]       SITES_V  = 17'(SITES);
	localparam logic [NA_W-1:0]   WRAP_V   = NA_W'(SITES - SIDE);
	localparam logic [NA_W-1:0]   SIDE_NA  = NA_W'(SIDE);
	localparam logic [NA_W-1:0]   SIDEM_NA = NA_W'(SIDE - 1);
	localparam logic [SITE_W-1:0] SIDE_S   = SITE_W'(SIDE);
	localparam logic [SITE_W-1:0] LASTROW  = SITE_W'(SIDE - 1);
	localparam logic [SITE_W:0]   SIDEM_W  = (SITE_W+1)'(SIDE - 1);

	// item registers
	logic [SITE_W-1:0] site_q;
	logic [RND_W-1:0]  rnd_q;
	logic [SITE_W-1:0] row_q;
	logic [SITE_W-1:0] base_q;
	logic              spin_q;
	logic [1:0]        ud_q;
	logic              oor_a_q;
	logic              oor_b_q;
	logic [ADDR_W-1:0] clr_q;
	logic [MAG_W-1:0]  mag_q;
	logic              rsp_valid_q;
	logic              accepted_q;
	logic              new_spin_q;

	// memory side
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic              wdata;
	logic              re_a;
	logic              re_b;
	logic [NA_W-1:0]   addr_a;
	logic [NA_W-1:0]   addr_b;
	logic              rd_a;
	logic              rd_b;

	logic [PROD_W-1:0] prod;
	logic [SITE_W-1:0] row_d;
	logic [SITE_W-1:0] base_d;
	logic [NA_W-1:0]   site_na;
	logic [NA_W-1:0]   up_addr;
	logic [NA_W-1:0]   dn_addr;
	logic [NA_W-1:0]   lf_addr;
	logic [NA_W-1:0]   rt_addr;
	logic              col_first;
	logic              col_last;
	logic              nb_a;
	logic              nb_b;
	logic [2:0]        up_cnt;
	logic [IDX_W-1:0]  idx;
	logic [THR_W-1:0]  thr;
	logic              site_ok;
	logic              flip;

	// latch the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			site_q <= site;
			rnd_q  <= accept_random;
		end
	end

	// row by reciprocal multiply, then row start
	assign prod   = PROD_W'(site_q) * PROD_W'(DIV_M);
	assign row_d  = prod[DIV_S +: SITE_W];
	assign base_d = row_q * SIDE_S;

	always_ff @(posedge clk) begin
		if (cmd.step_row) row_q <= row_d;
		if (cmd.step_base) base_q <= base_d;
	end

	// wrapped neighbour addresses
	assign site_na   = NA_W'(site_q);
	assign up_addr   = (row_q == '0) ? site_na + WRAP_V : site_na - SIDE_NA;
	assign dn_addr   = (row_q == LASTROW) ? site_na - WRAP_V : site_na + SIDE_NA;
	assign col_first = (site_q == base_q);
	assign col_last  = ({1'b0, site_q} == ({1'b0, base_q} + SIDEM_W));
	assign lf_addr   = col_first ? site_na + SIDEM_NA : site_na - NA_W'(1);
	assign rt_addr   = col_last ? NA_W'(base_q) : site_na + NA_W'(1);

	// read port selection
	always_comb begin
		re_a   = cmd.step_row | cmd.step_base | cmd.step_sides;
		re_b   = cmd.step_base | cmd.step_sides;
		addr_a = site_na;
		addr_b = dn_addr;
		if (cmd.step_base) begin
			addr_a = up_addr;
		end else if (cmd.step_sides) begin
			addr_a = lf_addr;
			addr_b = rt_addr;
		end
	end

	// sites past the stored range are never written: they read as up
	always_ff @(posedge clk) begin
		if (re_a) oor_a_q <= ({1'b0, addr_a} >= DEPTH_V);
		if (re_b) oor_b_q <= ({1'b0, addr_b} >= DEPTH_V);
	end

	assign nb_a = oor_a_q | rd_a;
	assign nb_b = oor_b_q | rd_b;

	// collect own spin and vertical neighbours
	always_ff @(posedge clk) begin
		if (cmd.step_base) spin_q <= rd_a;
		if (cmd.step_sides) ud_q <= {1'b0, nb_a} + {1'b0, nb_b};
	end

	// threshold test
	assign up_cnt  = {1'b0, ud_q} + {2'b0, nb_a} + {2'b0, nb_b};
	assign idx     = spin_q ? IDX_W'(5) + IDX_W'(up_cnt) : IDX_W'(up_cnt);
	assign thr     = (idx < IDX_W'(TBL_N)) ? thr_table[idx] : '0;
	assign site_ok = ({5'b0, site_q} < SITES_V);
	assign flip    = site_ok & ({1'b0, rnd_q} < thr);

	// memory write: clearing pass or flip
	assign we    = cmd.clear | (cmd.decide & flip);
	assign waddr = cmd.clear ? clr_q : site_q[ADDR_W-1:0];
	assign wdata = cmd.clear | ~spin_q;

	isingm_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_spins (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (re_a),
		.raddr_a (addr_a[ADDR_W-1:0]),
		.rdata_a (rd_a),
		.re_b    (re_b),
		.raddr_b (addr_b[ADDR_W-1:0]),
		.rdata_b (rd_b)
	);

	// clearing pass counter, magnetization, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			mag_q       <= MAG_W'(SITES);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + ADDR_W'(1);
			if (cmd.decide && flip) begin
				mag_q <= spin_q ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
			end
			if (cmd.decide) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			accepted_q <= flip;
			new_spin_q <= site_ok & (spin_q ^ flip);
		end
	end

	assign sts.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.out_busy   = rsp_valid_q & ~rsp_ready;

	assign rsp_valid     = rsp_valid_q;
	assign accepted      = accepted_q;
	assign new_spin      = new_spin_q;
	assign magnetization = signed'(mag_q);

endmodule
